### src/tea_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types, constants and round helpers for the TEA cipher unit.
// ----------------------------------------------------------------------------
package tea_pkg;

    localparam int ROUNDS   = 32;
    localparam int NSTAGE   = 2 * ROUNDS;   // one half-round per stage
    localparam int WORD_W   = 32;
    localparam int CFG_IDX_W = 8;
    localparam logic [WORD_W-1:0] DELTA = 32'h9e37_79b9;

    // queue between front and back
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    // key register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 8'd3;

    typedef enum logic {
        OP_ENC = 1'b0,
        OP_DEC = 1'b1
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [WORD_W-1:0] first;
        logic [WORD_W-1:0] second;
    } t_item;

    typedef struct packed {
        logic [WORD_W-1:0] k0;
        logic [WORD_W-1:0] k1;
        logic [WORD_W-1:0] k2;
        logic [WORD_W-1:0] k3;
    } t_key;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_q_status;

    typedef struct packed {
        logic valid;
        logic push;
    } t_front_status;

    function automatic logic [WORD_W-1:0] tea_mix(
        input logic [WORD_W-1:0] x,
        input logic [WORD_W-1:0] sum,
        input logic [WORD_W-1:0] ka,
        input logic [WORD_W-1:0] kb
    );
        return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
    endfunction

    // round sum used by half-round stage j (stages 2r and 2r+1 share round r)
    function automatic logic [WORD_W-1:0] tea_sum(input int j, input t_op op);
        int r;
        logic [WORD_W-1:0] mult;
        r = j >> 1;
        if (op == OP_DEC) begin
            mult = WORD_W'(ROUNDS - r);
        end else begin
            mult = WORD_W'(r + 1);
        end
        return mult * DELTA;
    endfunction

endpackage

### src/tea_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_front
// Accepts input blocks and key writes, decodes the operation, feeds the queue.
// ----------------------------------------------------------------------------
module tea_front import tea_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_func,
    input  logic [WORD_W-1:0]    i_first_word,
    input  logic [WORD_W-1:0]    i_second_word,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data,
    input  logic                 i_q_ready,
    output t_item                o_q_item,
    output t_front_status        o_status,
    output t_key                 o_key
);

    logic  r_valid;
    t_item r_item;
    t_key  r_key;
    logic  accept;
    logic  push;

    assign push       = r_valid && i_q_ready;
    assign o_in_ready = !r_valid || i_q_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.op     <= i_func ? OP_DEC : OP_ENC;
            r_item.first  <= i_first_word;
            r_item.second <= i_second_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_KEY0: r_key.k0 <= i_cfg_data;
                REG_KEY1: r_key.k1 <= i_cfg_data;
                REG_KEY2: r_key.k2 <= i_cfg_data;
                REG_KEY3: r_key.k3 <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_q_item       = r_item;
    assign o_status.valid = r_valid;
    assign o_status.push  = push;
    assign o_key          = r_key;

endmodule

### src/tea_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_queue
// Short FIFO decoupling the front from the round pipeline.
// ----------------------------------------------------------------------------
module tea_queue import tea_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_item     i_item,
    input  logic      i_pop,
    output t_item     o_item,
    output t_q_status o_status
);

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item         = r_mem[r_rd_ptr];
    assign o_status.count = r_count;
    assign o_status.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

### src/tea_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_back
// Round pipeline: one half-round per stage, last stage is the output register.
// ----------------------------------------------------------------------------
module tea_back import tea_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_key              i_key,
    input  t_item             i_item,
    input  logic              i_q_empty,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [WORD_W-1:0] o_out_first,
    output logic [WORD_W-1:0] o_out_second
);

    logic              r_vld [NSTAGE+1];
    t_op               r_op  [NSTAGE+1];
    logic [WORD_W-1:0] r_y   [NSTAGE+1];
    logic [WORD_W-1:0] r_z   [NSTAGE+1];
    logic              adv;

    // whole pipe moves when the output slot is free or being taken
    assign adv   = !r_vld[NSTAGE] || i_out_ready;
    assign o_pop = adv && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= !i_q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_op[0] <= i_item.op;
            r_y[0]  <= i_item.first;
            r_z[0]  <= i_item.second;
        end
    end

    for (genvar j = 0; j < NSTAGE; j++) begin : g_stage
        localparam logic [WORD_W-1:0] SUM_ENC = tea_sum(j, OP_ENC);
        localparam logic [WORD_W-1:0] SUM_DEC = tea_sum(j, OP_DEC);
        localparam bit EVEN = ((j % 2) == 0);

        logic              upd_first;
        logic [WORD_W-1:0] src;
        logic [WORD_W-1:0] tgt;
        logic [WORD_W-1:0] ka;
        logic [WORD_W-1:0] kb;
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] m;
        logic [WORD_W-1:0] res;

        // encrypt updates y then z; decrypt updates z then y
        always_comb begin
            upd_first = ((r_op[j] == OP_ENC) == EVEN);
            src = upd_first ? r_z[j] : r_y[j];
            tgt = upd_first ? r_y[j] : r_z[j];
            ka  = upd_first ? i_key.k0 : i_key.k2;
            kb  = upd_first ? i_key.k1 : i_key.k3;
            sum = (r_op[j] == OP_DEC) ? SUM_DEC : SUM_ENC;
            m   = tea_mix(src, sum, ka, kb);
            res = (r_op[j] == OP_DEC) ? tgt - m : tgt + m;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else if (adv) begin
                r_vld[j+1] <= r_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_op[j+1] <= r_op[j];
                r_y[j+1]  <= upd_first ? res : r_y[j];
                r_z[j+1]  <= upd_first ? r_z[j] : res;
            end
        end
    end

    assign o_out_valid  = r_vld[NSTAGE];
    assign o_out_first  = r_y[NSTAGE];
    assign o_out_second = r_z[NSTAGE];

endmodule

### src/tea_block_cipher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_block_cipher_unit
// TEA encrypt/decrypt of 64-bit blocks under a 128-bit key, fully pipelined.
// ----------------------------------------------------------------------------
// Data path with no stalls: front register, queue, input register, then the
//   2*ROUNDS (64) half-round stages.
// Throughput: one block per cycle; the pipe holds while the result is not taken.
// Reset: synchronous, active low; clears valids, queue and keys (key = 0).
module tea_block_cipher_unit import tea_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_func,
    input  logic [WORD_W-1:0]    i_first_word,
    input  logic [WORD_W-1:0]    i_second_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [WORD_W-1:0]    o_out_first,
    output logic [WORD_W-1:0]    o_out_second,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    t_item         front_item;
    t_item         q_item;
    t_front_status front_st;
    t_q_status     q_st;
    t_key          key;
    logic          q_pop;

    tea_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_func       (i_func),
        .i_first_word (i_first_word),
        .i_second_word(i_second_word),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_q_ready    (!q_st.full),
        .o_q_item     (front_item),
        .o_status     (front_st),
        .o_key        (key)
    );

    tea_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_st.push),
        .i_item  (front_item),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_status(q_st)
    );

    tea_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       (key),
        .i_item      (q_item),
        .i_q_empty   (q_st.empty),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_first (o_out_first),
        .o_out_second(o_out_second)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(front_st.push && q_st.full))
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_st.empty))
        else $error("pop from empty queue");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (front_st.push && !q_pop && !q_st.full) |=> !q_st.empty)
        else $error("queue lost a beat");

    a_stall_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (front_st.valid && q_st.full))
        else $error("front stalled without cause");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the TEA cipher unit against a behavioral cipher model in the bench.
// Blocks are encrypted and decrypted under zero, extreme and random keys.
// Sender bursts and receiver stalls vary from phase to phase. Every result
// beat is compared in order with the model's prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import tea_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] first;
        logic [WORD_W-1:0] second;
    } t_block;

    // indexes outside the key map, written to check that they are ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hff;

    localparam int PHASES     = 8;
    localparam int PHASE_SIZE = 100;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    t_op                  func;
    logic [WORD_W-1:0]    first_word;
    logic [WORD_W-1:0]    second_word;
    logic                 out_valid;
    logic                 out_ready;
    logic [WORD_W-1:0]    out_first;
    logic [WORD_W-1:0]    out_second;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    t_key   key_model;
    t_block expected_blocks[$];
    int     err_count;

    // sender burst control
    int burst_left;
    bit tx_no_idle;

    // receiver stall pattern
    bit rx_pressure;
    bit rx_phase;
    int rx_left;

    tea_block_cipher_unit i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_func        (func),
        .i_first_word  (first_word),
        .i_second_word (second_word),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_out_first   (out_first),
        .o_out_second  (out_second),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // cipher model
    // ------------------------------------------------------------------
    function automatic logic [WORD_W-1:0] round_term(
        input logic [WORD_W-1:0] x,
        input logic [WORD_W-1:0] s,
        input logic [WORD_W-1:0] ka,
        input logic [WORD_W-1:0] kb
    );
        logic [WORD_W-1:0] shl, shr;
        shl = x << 4;
        shr = x >> 5;
        return (shl + ka) ^ (x + s) ^ (shr + kb);
    endfunction

    function automatic t_block tea_transform(input t_op op, input logic [WORD_W-1:0] a,
                                             input logic [WORD_W-1:0] b, input t_key k);
        logic [WORD_W-1:0] y, z, s;
        y = a;
        z = b;
        if (op == OP_DEC) begin
            s = WORD_W'(ROUNDS) * DELTA;
            for (int r = 0; r < ROUNDS; r++) begin
                z = z - round_term(y, s, k.k2, k.k3);
                y = y - round_term(z, s, k.k0, k.k1);
                s = s - DELTA;
            end
        end else begin
            s = '0;
            for (int r = 0; r < ROUNDS; r++) begin
                s = s + DELTA;
                y = y + round_term(z, s, k.k0, k.k1);
                z = z + round_term(y, s, k.k2, k.k3);
            end
        end
        return '{first: y, second: z};
    endfunction

    // ------------------------------------------------------------------
    // shared tasks
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic send_block(input t_op op, input logic [WORD_W-1:0] a,
                              input logic [WORD_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = tx_no_idle ? 1000 : $urandom_range(1, 12);
            gap = tx_no_idle ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid    <= 1'b1;
        func        <= op;
        first_word  <= a;
        second_word <= b;
        do @(posedge clk); while (!in_ready);
        expected_blocks.push_back(tea_transform(op, a, b, key_model));
    endtask

    task automatic sender_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic wait_drain();
        sender_idle();
        while (expected_blocks.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_KEY0: key_model.k0 = data;
            REG_KEY1: key_model.k1 = data;
            REG_KEY2: key_model.k2 = data;
            REG_KEY3: key_model.k3 = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_key(input t_key k);
        write_reg(REG_KEY0, k.k0);
        write_reg(REG_KEY1, k.k1);
        write_reg(REG_KEY2, k.k2);
        write_reg(REG_KEY3, k.k3);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        logic [WORD_W-1:0] bit_k;
        bit_k = 32'h1 << $urandom_range(0, WORD_W - 1);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return bit_k;
            3: return ~bit_k;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // receiver: alternating runs of ready and stall
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (rx_left > 0) begin
            rx_left--;
        end else begin
            rx_phase = !rx_phase;
            rx_left  = rx_phase ? $urandom_range(0, 24) : $urandom_range(0, 19);
        end
        out_ready <= !rx_pressure || rx_phase;
    end

    // result checker
    always @(posedge clk) begin
        t_block want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_blocks.size() == 0) begin
                report_mismatch($sformatf("result beat %h_%h with none expected",
                                          out_first, out_second));
            end else begin
                want = expected_blocks.pop_front();
                if (out_first !== want.first)
                    report_mismatch($sformatf("out_first %h, expected %h",
                                              out_first, want.first));
                if (out_second !== want.second)
                    report_mismatch($sformatf("out_second %h, expected %h",
                                              out_second, want.second));
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_zero_key();
        // key registers never written after reset
        send_block(OP_ENC, '0, '0);
        send_block(OP_DEC, '0, '0);
        send_block(OP_ENC, '1, '1);
        send_block(OP_DEC, '1, '1);
        wait_drain();
    endtask

    task automatic test_extreme_keys();
        load_key('{k0: '1, k1: '1, k2: '1, k3: '1});
        send_block(OP_ENC, '0, '1);
        send_block(OP_DEC, '1, '0);
        send_block(OP_ENC, 32'h8000_0000, 32'h0000_0001);
        send_block(OP_DEC, 32'h0000_0001, 32'h8000_0000);
        wait_drain();
        load_key('{k0: '1, k1: '0, k2: 32'h8000_0000, k3: 32'h0000_0001});
        send_block(OP_ENC, 32'h0123_4567, 32'h89ab_cdef);
        send_block(OP_DEC, 32'h0123_4567, 32'h89ab_cdef);
        wait_drain();
    endtask

    task automatic test_unused_index();
        write_reg(REG_UNUSED_LO, '1);
        write_reg(REG_UNUSED_HI, 32'h5a5a_a5a5);
        write_reg(CFG_IDX_W'($urandom_range(5, 254)), $urandom);
        send_block(OP_ENC, 32'hdead_beef, 32'h0bad_f00d);
        send_block(OP_DEC, 32'hdead_beef, 32'h0bad_f00d);
        wait_drain();
    endtask

    task automatic test_random_traffic();
        t_key k;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       k = '{k0: '0, k1: '1, k2: '0, k3: '1};
                1:       k = '{k0: '1, k1: '0, k2: '1, k3: '0};
                default: k = '{k0: $urandom, k1: $urandom, k2: $urandom, k3: $urandom};
            endcase
            load_key(k);
            tx_no_idle  = (p % 4 == 1);
            rx_pressure = (p % 4 != 2);
            for (int n = 0; n < PHASE_SIZE; n++)
                send_block(t_op'($urandom_range(0, 1)), pick_word(), pick_word());
            wait_drain();
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        int guard;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        func        = OP_ENC;
        first_word  = '0;
        second_word = '0;
        out_ready   = 1'b1;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        key_model   = '0;
        err_count   = 0;
        burst_left  = 0;
        tx_no_idle  = 1'b0;
        rx_pressure = 1'b1;
        rx_phase    = 1'b1;
        rx_left     = 0;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_zero_key();
        test_extreme_keys();
        test_unused_index();
        test_random_traffic();

        sender_idle();
        guard = 0;
        while (expected_blocks.size() != 0 && guard < 20000) begin
            @(posedge clk);
            guard++;
        end
        // catch any stray beats after the pipe should be empty
        repeat (2 * NSTAGE + 20) @(posedge clk);
        if (expected_blocks.size() != 0)
            report_mismatch($sformatf("%0d result beats never arrived",
                                      expected_blocks.size()));

        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("TIMEOUT @%0t", $time);
        $display("== FAIL ==");
        $finish;
    end

endmodule
